// ----- src/sdzcd_pkg.sv -----
// Shared types and constants for the stick dead zone and center detection block.
// Used by the channel interfaces and by every module of the block; depends on nothing.
package sdzcd_pkg;

    localparam int IDX_W      = 4;
    localparam int CH_W       = 4;
    localparam int RAW_W      = 12;
    localparam int VAL_W      = 12;
    localparam int LVL_W      = 3;
    localparam int PSI_W      = 5;
    localparam int EN_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int FULL_SCALE = 1024;
    localparam int FS_SHIFT   = 10;
    localparam int MAG_W      = 11;
    localparam int OFF_W      = 8;
    localparam int CTR_SHIFT  = 4;
    localparam int DIV_N_W    = 20;
    localparam int DIV_D_W    = 11;
    localparam int DIV_CNT_W  = $clog2(DIV_N_W);
    localparam int Q_DEPTH    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEAD_ZONE  = 3'd0,
        REG_THR_REV    = 3'd1,
        REG_THR_CH     = 3'd2,
        REG_BEEP_EN    = 3'd3,
        REG_POTS_START = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [LVL_W-1:0] dead_zone_level;
        logic             throttle_reverse;
        logic [CH_W-1:0]  throttle_channel;
        logic [EN_W-1:0]  center_beep_enable;
        logic [PSI_W-1:0] pots_start_index;
    } cfg_t;

    // One classified word passed from the front end to the back end.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CH_W-1:0]  ch;
        logic             is_stick;
        logic             is_throttle;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic             normal;
        logic             pot_ok;
        logic             first_done;
        logic             calib;
        logic             last;
    } item_t;

    function automatic logic [OFF_W-1:0] dz_offset(input logic [LVL_W-1:0] level);
        logic [LVL_W-1:0] sh;
        sh = level - LVL_W'(1);
        dz_offset = OFF_W'(2) << sh;
    endfunction

endpackage

// ----- src/sdzcd_in_if.sv -----
// Input channel carrying one raw analog sample word with its scan flags.
// Depends on sdzcd_pkg for field widths.
interface sdzcd_in_if;
    logic                          valid;
    logic                          ready;
    logic [sdzcd_pkg::IDX_W-1:0]   input_index;
    logic [sdzcd_pkg::CH_W-1:0]    mapped_channel;
    logic [sdzcd_pkg::RAW_W-1:0]   raw_sample;
    logic                          normal_mode;
    logic                          pot_available;
    logic                          first_run_done;
    logic                          calibrating;
    logic                          last_of_scan;

    modport source (output valid, input ready, output input_index, mapped_channel,
                    raw_sample, normal_mode, pot_available, first_run_done,
                    calibrating, last_of_scan);
    modport sink (input valid, output ready, input input_index, mapped_channel,
                  raw_sample, normal_mode, pot_available, first_run_done,
                  calibrating, last_of_scan);
endinterface

// ----- src/sdzcd_out_if.sv -----
// Output channel carrying one conditioned value word and its beep request.
// Depends on sdzcd_pkg for field widths.
interface sdzcd_out_if;
    logic                               valid;
    logic                               ready;
    logic [sdzcd_pkg::IDX_W-1:0]        value_index;
    logic signed [sdzcd_pkg::VAL_W-1:0] conditioned_value;
    logic                               beep_request;

    modport source (output valid, input ready, output value_index, conditioned_value,
                    beep_request);
    modport sink (input valid, output ready, input value_index, conditioned_value,
                  beep_request);
endinterface

// ----- src/sdzcd_cfg_if.sv -----
// Configuration write channel: register index and write data.
// Depends on sdzcd_pkg for field widths.
interface sdzcd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sdzcd_pkg::CFG_IDX_W-1:0]  index;
    logic [sdzcd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, input ready, output index, data);
    modport sink (input valid, output ready, input index, data);
endinterface

// ----- src/sdzcd_front.sv -----
// Front end: accepts sample words, centres and saturates them and works out the channel.
// Depends on sdzcd_pkg and sdzcd_in_if.
module sdzcd_front (
    input  logic              clk,
    input  logic              rst_n,
    sdzcd_in_if.sink          in_ch,
    input  sdzcd_pkg::cfg_t   cfg_q,
    output logic              push_valid,
    input  logic              push_ready,
    output sdzcd_pkg::item_t  push_data
);
    import sdzcd_pkg::*;

    logic        stage_valid_reg, stage_valid_next;
    item_t       stage_item_reg, stage_item_next;
    item_t       cls;
    logic signed [RAW_W:0] v;
    logic        take;

    assign in_ch.ready = !stage_valid_reg || push_ready;
    assign take        = in_ch.valid && in_ch.ready;
    assign push_valid  = stage_valid_reg;
    assign push_data   = stage_item_reg;

    always_comb
    begin
        v = $signed({1'b0, in_ch.raw_sample}) - (RAW_W+1)'(FULL_SCALE);
        cls.idx        = in_ch.input_index;
        cls.is_stick   = {1'b0, in_ch.input_index} < cfg_q.pots_start_index;
        cls.ch         = cls.is_stick ? in_ch.mapped_channel : in_ch.input_index;
        cls.is_throttle = (cls.ch == cfg_q.throttle_channel);
        // Samples above full scale saturate; the low side cannot go below it.
        if (v > $signed((RAW_W+1)'(FULL_SCALE)))
        begin
            cls.neg = 1'b0;
            cls.mag = MAG_W'(FULL_SCALE);
        end
        else
        begin
            cls.neg = v[RAW_W];
            cls.mag = v[RAW_W] ? MAG_W'(-v) : MAG_W'(v);
        end
        cls.normal     = in_ch.normal_mode;
        cls.pot_ok     = in_ch.pot_available;
        cls.first_done = in_ch.first_run_done;
        cls.calib      = in_ch.calibrating;
        cls.last       = in_ch.last_of_scan;

        stage_valid_next = stage_valid_reg;
        stage_item_next  = stage_item_reg;
        if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
        if (take)
        begin
            stage_valid_next = 1'b1;
            stage_item_next  = cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_item_reg <= stage_item_next;
    end

endmodule

// ----- src/sdzcd_fifo.sv -----
// Short queue of classified words between the front end and the back end.
// Depends on sdzcd_pkg for the word type and depth.
module sdzcd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  sdzcd_pkg::item_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output sdzcd_pkg::item_t pop_data
);
    import sdzcd_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    item_t            mem [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/sdzcd_back.sv -----
// Back end: dead zone rescale through a bit-serial divider, centre detection and output word.
// Depends on sdzcd_pkg and sdzcd_out_if.
module sdzcd_back #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  sdzcd_pkg::item_t pop_data,
    input  sdzcd_pkg::cfg_t  cfg_q,
    sdzcd_out_if.source      out_ch
);
    import sdzcd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN} state_t;

    state_t                  state_reg, state_next;
    item_t                   cur_reg, cur_next;
    logic [DIV_N_W-1:0]      num_reg, num_next;
    logic [DIV_D_W-1:0]      div_reg, div_next;
    logic [DIV_D_W-1:0]      rem_reg, rem_next;
    logic [MAG_W-1:0]        quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MAG_W-1:0]        res_mag_reg, res_mag_next;
    logic                    res_neg_reg, res_neg_next;
    logic [NUM_CHANNELS-1:0] prev_mask_reg, prev_mask_next;
    logic [NUM_CHANNELS-1:0] scan_mask_reg, scan_mask_next;
    logic                    out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]        out_idx_reg, out_idx_next;
    logic signed [VAL_W-1:0] out_val_reg, out_val_next;
    logic                    out_beep_reg, out_beep_next;

    logic [OFF_W-1:0]        off;
    logic                    bypass;
    logic                    needs_div;
    logic [MAG_W-1:0]        diff;
    logic [DIV_D_W-1:0]      trial;
    logic                    trial_ge;
    logic                    has_bit;
    logic [NUM_CHANNELS-1:0] chan_mask;
    logic [NUM_CHANNELS-1:0] scan_upd;
    logic                    was;
    logic [MAG_W-CTR_SHIFT-1:0] m16;
    logic                    centered;
    logic                    hit;
    logic [VAL_W-1:0]        mag_ext;
    logic                    can_emit;

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.value_index       = out_idx_reg;
    assign out_ch.conditioned_value = out_val_reg;
    assign out_ch.beep_request      = out_beep_reg;
    assign pop_ready                = (state_reg == S_IDLE);

    always_comb
    begin
        off       = dz_offset(cfg_q.dead_zone_level);
        bypass    = (cfg_q.dead_zone_level == '0) || pop_data.is_throttle;
        needs_div = !bypass && (pop_data.mag > MAG_W'(off));
        diff      = pop_data.mag - MAG_W'(off);
        trial     = {rem_reg[DIV_D_W-2:0], num_reg[DIV_N_W-1]};
        trial_ge  = (trial >= div_reg);

        has_bit   = (32'(cur_reg.ch) < NUM_CHANNELS);
        chan_mask = has_bit ? (NUM_CHANNELS'(1) << cur_reg.ch) : '0;
        was       = |(prev_mask_reg & chan_mask);
        m16       = res_mag_reg[MAG_W-1:CTR_SHIFT];
        // Hysteresis: one step off centre still counts while the channel was centred.
        centered  = (m16 == '0) || ((m16 == (MAG_W-CTR_SHIFT)'(1)) && was);
        hit       = cur_reg.normal && has_bit && centered;
        scan_upd  = hit ? (scan_mask_reg | chan_mask) : scan_mask_reg;
        mag_ext   = {1'b0, res_mag_reg};
        can_emit  = !out_valid_reg || out_ch.ready;

        state_next     = state_reg;
        cur_next       = cur_reg;
        num_next       = num_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        res_mag_next   = res_mag_reg;
        res_neg_next   = res_neg_reg;
        prev_mask_next = prev_mask_reg;
        scan_mask_next = scan_mask_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_val_next   = out_val_reg;
        out_beep_next  = out_beep_reg;

        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    cur_next = pop_data;
                    if (needs_div)
                    begin
                        // (|v| - off) * 1024 / (1024 - off), magnitude only.
                        num_next     = {diff[FS_SHIFT-1:0], {FS_SHIFT{1'b0}}};
                        div_next     = DIV_D_W'(FULL_SCALE) - DIV_D_W'(off);
                        rem_next     = '0;
                        quo_next     = '0;
                        cnt_next     = DIV_CNT_W'(DIV_N_W - 1);
                        res_neg_next = pop_data.neg;
                        state_next   = S_DIV;
                    end
                    else
                    begin
                        res_mag_next = bypass ? pop_data.mag : '0;
                        res_neg_next = pop_data.neg ^
                                       (pop_data.is_throttle && cfg_q.throttle_reverse);
                        state_next   = S_FIN;
                    end
                end
            end
            S_DIV:
            begin
                num_next = {num_reg[DIV_N_W-2:0], 1'b0};
                rem_next = trial_ge ? (trial - div_reg) : trial;
                quo_next = {quo_reg[MAG_W-2:0], trial_ge};
                cnt_next = cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    res_mag_next = quo_next;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = cur_reg.idx;
                    out_val_next   = res_neg_reg ? $signed(-mag_ext) : $signed(mag_ext);
                    out_beep_next  = hit && cfg_q.center_beep_enable[cur_reg.ch] && !was &&
                                     cur_reg.first_done && !cur_reg.calib &&
                                     (cur_reg.is_stick || cur_reg.pot_ok);
                    scan_mask_next = scan_upd;
                    if (cur_reg.last)
                    begin
                        if (cur_reg.normal)
                        begin
                            prev_mask_next = scan_upd;
                        end
                        scan_mask_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            num_reg       <= '0;
            div_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            res_mag_reg   <= '0;
            res_neg_reg   <= 1'b0;
            prev_mask_reg <= '0;
            scan_mask_reg <= '0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_val_reg   <= '0;
            out_beep_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            num_reg       <= num_next;
            div_reg       <= div_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            cnt_reg       <= cnt_next;
            res_mag_reg   <= res_mag_next;
            res_neg_reg   <= res_neg_next;
            prev_mask_reg <= prev_mask_next;
            scan_mask_reg <= scan_mask_next;
            out_valid_reg <= out_valid_next;
            out_idx_reg   <= out_idx_next;
            out_val_reg   <= out_val_next;
            out_beep_reg  <= out_beep_next;
        end
    end

endmodule

// ----- src/stick_dead_zone_and_center_detect_top.sv -----
// Stick dead zone and centre detection. Each sample word is centred to -1024..1024,
// dead-zoned and rescaled on non-throttle channels, optionally reversed on the throttle,
// and checked for centring. A word that falls inside the dead zone, sits on the throttle
// or meets a zero dead-zone level skips the divider; a word that needs rescaling passes
// through the 20-step bit-serial divider in the back end. Words are handled one at a time
// in the back end, while the front end and a two-word queue keep accepting as long as they
// have room. Configuration writes complete in the cycle they are offered.
module stick_dead_zone_and_center_detect_top #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    sdzcd_in_if.sink    in_ch,
    sdzcd_out_if.source out_ch,
    sdzcd_cfg_if.sink   cfg
);
    import sdzcd_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  push_valid, push_ready;
    item_t push_data;
    logic  pop_valid, pop_ready;
    item_t pop_data;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_DEAD_ZONE:  cfg_next.dead_zone_level    = cfg.data[LVL_W-1:0];
                REG_THR_REV:    cfg_next.throttle_reverse   = cfg.data[0];
                REG_THR_CH:     cfg_next.throttle_channel   = cfg.data[CH_W-1:0];
                REG_BEEP_EN:    cfg_next.center_beep_enable = cfg.data[EN_W-1:0];
                REG_POTS_START: cfg_next.pots_start_index   = cfg.data[PSI_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dead_zone_level    <= '0;
            cfg_reg.throttle_reverse   <= 1'b0;
            cfg_reg.throttle_channel   <= '0;
            cfg_reg.center_beep_enable <= '0;
            cfg_reg.pots_start_index   <= PSI_W'(4);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sdzcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg_q      (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sdzcd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sdzcd_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .cfg_q     (cfg_reg),
        .out_ch    (out_ch)
    );

endmodule

// ----- test/tb_stick_dead_zone_and_center_detect_top.sv -----
// Self-checking bench for stick_dead_zone_and_center_detect_top: directed scans, then
// random scans under several register settings, with bursty input and a stalling output.
// Depends on sdzcd_pkg and the in, out and cfg channel interfaces.
module tb_stick_dead_zone_and_center_detect_top;
    import sdzcd_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_WORDS  = 245;

    typedef struct packed {
        logic [IDX_W-1:0] input_index;
        logic [CH_W-1:0]  mapped_channel;
        logic [RAW_W-1:0] raw_sample;
        logic             normal_mode;
        logic             pot_available;
        logic             first_run_done;
        logic             calibrating;
        logic             last_of_scan;
    } sample_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] value_index;
        logic [VAL_W-1:0] conditioned_value;
        logic             beep_request;
    } value_word_t;

    logic clk = 1'b0;
    logic rst_n;

    sdzcd_in_if  in_bus();
    sdzcd_out_if out_bus();
    sdzcd_cfg_if cfg_bus();

    stick_dead_zone_and_center_detect_top #(
        .NUM_CHANNELS(16)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus),
        .cfg    (cfg_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register copies and centre masks held by the predictor.
    logic [LVL_W-1:0] cfg_dead_zone;
    logic             cfg_thr_rev;
    logic [CH_W-1:0]  cfg_thr_ch;
    logic [EN_W-1:0]  cfg_beep_en;
    logic [PSI_W-1:0] cfg_pots_start;
    logic [15:0]      centred_prev;
    logic [15:0]      centred_scan;

    sample_word_t pending_samples[$];
    value_word_t  expected_values[$];
    int           mismatches = 0;
    int           hold_req = 0;

    // Works out the value word for one accepted sample word and advances the centre masks.
    function automatic value_word_t condition_sample(input sample_word_t w);
        logic        stick;
        logic [3:0]  ch;
        logic [15:0] ch_bit;
        logic        was;
        int          v;
        int          off;
        int          mag;
        value_word_t r;
        stick  = {1'b0, w.input_index} < cfg_pots_start;
        ch     = stick ? w.mapped_channel : w.input_index;
        ch_bit = 16'd1 << ch;
        v = int'(w.raw_sample) - 1024;
        if (v > 1024)
            v = 1024;
        if (ch != cfg_thr_ch)
        begin
            if (cfg_dead_zone != 0)
            begin
                off = 2 << (int'(cfg_dead_zone) - 1);
                if (v > off)
                    v = (v - off) * 1024 / (1024 - off);
                else if (v < -off)
                    v = (v + off) * 1024 / (1024 - off);
                else
                    v = 0;
            end
        end
        else if (cfg_thr_rev)
        begin
            v = -v;
        end
        mag = (v < 0 ? -v : v) / 16;
        r.beep_request = 1'b0;
        if (w.normal_mode)
        begin
            was = |(centred_prev & ch_bit);
            if (mag == 0 || (mag == 1 && was))
            begin
                centred_scan = centred_scan | ch_bit;
                if (|(cfg_beep_en & ch_bit) && !was && w.first_run_done && !w.calibrating
                    && (stick || w.pot_available))
                    r.beep_request = 1'b1;
            end
        end
        if (w.last_of_scan)
        begin
            if (w.normal_mode)
                centred_prev = centred_scan;
            centred_scan = '0;
        end
        r.value_index       = w.input_index;
        r.conditioned_value = v[VAL_W-1:0];
        return r;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    sample_word_t shown;
    int           burst_left;
    int           gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_bus.valid          <= 1'b0;
            in_bus.input_index    <= '0;
            in_bus.mapped_channel <= '0;
            in_bus.raw_sample     <= '0;
            in_bus.normal_mode    <= 1'b0;
            in_bus.pot_available  <= 1'b0;
            in_bus.first_run_done <= 1'b0;
            in_bus.calibrating    <= 1'b0;
            in_bus.last_of_scan   <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (in_bus.valid && in_bus.ready)
                expected_values.push_back(condition_sample(shown));
            if (in_bus.valid && !in_bus.ready)
            begin
                // The word on offer has not been taken yet, so it stays put.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_bus.valid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                shown = pending_samples.pop_front();
                in_bus.valid          <= 1'b1;
                in_bus.input_index    <= shown.input_index;
                in_bus.mapped_channel <= shown.mapped_channel;
                in_bus.raw_sample     <= shown.raw_sample;
                in_bus.normal_mode    <= shown.normal_mode;
                in_bus.pot_available  <= shown.pot_available;
                in_bus.first_run_done <= shown.first_run_done;
                in_bus.calibrating    <= shown.calibrating;
                in_bus.last_of_scan   <= shown.last_of_scan;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each value word and stalls on a changing pattern of its own.
    int          hold_seen;
    int          hold_left;
    int          rx_mode;
    int          rx_mode_left;
    int          rx_tick;
    value_word_t exp_word;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
            hold_seen    = 0;
            hold_left    = 0;
            rx_mode      = 0;
            rx_mode_left = 0;
            rx_tick      = 0;
        end
        else
        begin
            if (out_bus.valid && out_bus.ready)
            begin
                if (expected_values.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 40)
                        $display("%0t: value word for index %0d with nothing expected",
                                 $time, out_bus.value_index);
                end
                else
                begin
                    exp_word = expected_values.pop_front();
                    if (out_bus.value_index !== exp_word.value_index)
                    begin
                        mismatches++;
                        if (mismatches <= 40)
                            $display("%0t: value_index expected %0d actual %0d", $time,
                                     exp_word.value_index, out_bus.value_index);
                    end
                    if (out_bus.conditioned_value !== exp_word.conditioned_value)
                    begin
                        mismatches++;
                        if (mismatches <= 40)
                            $display("%0t: conditioned_value (index %0d) expected %0d actual %0d",
                                     $time, exp_word.value_index,
                                     $signed(exp_word.conditioned_value),
                                     $signed(out_bus.conditioned_value));
                    end
                    if (out_bus.beep_request !== exp_word.beep_request)
                    begin
                        mismatches++;
                        if (mismatches <= 40)
                            $display("%0t: beep_request (index %0d) expected %0b actual %0b",
                                     $time, exp_word.value_index, exp_word.beep_request,
                                     out_bus.beep_request);
                    end
                end
            end
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end
            else
            begin
                if (rx_mode_left == 0)
                begin
                    rx_mode      = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(20, 120);
                end
                else
                begin
                    rx_mode_left--;
                end
                rx_tick++;
                case (rx_mode)
                    0:       out_bus.ready <= 1'b1;
                    1:       out_bus.ready <= 1'($urandom_range(0, 1));
                    2:       out_bus.ready <= ($urandom_range(0, 7) != 0);
                    default: out_bus.ready <= rx_tick[2];
                endcase
            end
        end
    end

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= r;
        cfg_bus.data  <= d;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (r)
            REG_DEAD_ZONE:  cfg_dead_zone  = d[LVL_W-1:0];
            REG_THR_REV:    cfg_thr_rev    = d[0];
            REG_THR_CH:     cfg_thr_ch     = d[CH_W-1:0];
            REG_BEEP_EN:    cfg_beep_en    = d[EN_W-1:0];
            REG_POTS_START: cfg_pots_start = d[PSI_W-1:0];
            default:        ;
        endcase
    endtask

    task automatic set_all(input logic [15:0] lvl, input logic [15:0] rev,
                           input logic [15:0] thr, input logic [15:0] en,
                           input logic [15:0] pots);
        write_reg(REG_DEAD_ZONE, lvl);
        write_reg(REG_THR_REV, rev);
        write_reg(REG_THR_CH, thr);
        write_reg(REG_BEEP_EN, en);
        write_reg(REG_POTS_START, pots);
    endtask

    // Waits until every word offered has come back, then lets the back end settle.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_samples.size() != 0 || in_bus.valid || expected_values.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic sample_word_t mk(input int idx, input int ch, input int raw,
                                        input bit normal, input bit pot, input bit first,
                                        input bit calib, input bit last);
        sample_word_t w;
        w.input_index    = idx[IDX_W-1:0];
        w.mapped_channel = ch[CH_W-1:0];
        w.raw_sample     = raw[RAW_W-1:0];
        w.normal_mode    = normal;
        w.pot_available  = pot;
        w.first_run_done = first;
        w.calibrating    = calib;
        w.last_of_scan   = last;
        return w;
    endfunction

    // Samples cluster around centre and the dead-zone edge, where the detector lives.
    function automatic int pick_raw();
        int off;
        int sgn;
        off = (cfg_dead_zone == 0) ? 0 : (2 << (int'(cfg_dead_zone) - 1));
        sgn = $urandom_range(0, 1) ? 1 : -1;
        case ($urandom_range(0, 9))
            0, 1, 2: return 1024 + sgn * int'($urandom_range(0, 40));
            3, 4:    return 1024 + sgn * (off + int'($urandom_range(0, 40)));
            5:       return ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1)) ? 2048 : 1024);
            6:       return $urandom_range(2049, 4095);
            default: return $urandom_range(0, 2048);
        endcase
    endfunction

    task automatic push_scan(output int count);
        int  n;
        int  rot;
        bit  normal;
        bit  broken;
        sample_word_t w;
        n      = $urandom_range(4, 16);
        rot    = $urandom_range(0, 15);
        normal = ($urandom_range(0, 6) != 0);
        broken = ($urandom_range(0, 11) == 0);
        for (int i = 0; i < n; i++)
        begin
            w.input_index    = broken ? IDX_W'($urandom_range(0, 15)) : IDX_W'(i);
            w.mapped_channel = (i < 4) ? CH_W'((i + rot) % 4) : CH_W'((i + rot) % 16);
            w.raw_sample     = RAW_W'(pick_raw());
            w.normal_mode    = normal ^ ($urandom_range(0, 19) == 0);
            w.pot_available  = ($urandom_range(0, 9) < 7);
            w.first_run_done = ($urandom_range(0, 9) != 0);
            w.calibrating    = ($urandom_range(0, 9) == 0);
            w.last_of_scan   = broken ? ($urandom_range(0, 3) == 0) : (i == n - 1);
            pending_samples.push_back(w);
        end
        count = n;
    endtask

    task automatic run_phase(input bit long_hold);
        int made;
        int n;
        made = 0;
        // A long receiver hold while the sender keeps offering fills the block up.
        if (long_hold)
            hold_req++;
        while (made < PHASE_WORDS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                pending_samples.push_back(sample_word_t'($urandom));
                made++;
            end
            else
            begin
                push_scan(n);
                made += n;
            end
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_bus.valid  = 1'b0;
        cfg_bus.index  = REG_DEAD_ZONE;
        cfg_bus.data   = '0;
        cfg_dead_zone  = '0;
        cfg_thr_rev    = 1'b0;
        cfg_thr_ch     = '0;
        cfg_beep_en    = '0;
        cfg_pots_start = PSI_W'(4);
        centred_prev   = '0;
        centred_scan   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed scans: dead zone of eight, reversed throttle on channel two.
        set_all(16'd3, 16'd1, 16'd2, 16'hFFFF, 16'd4);
        pending_samples.push_back(mk(0, 0, 1024, 1, 1, 1, 0, 0));
        pending_samples.push_back(mk(1, 1, 0, 1, 1, 1, 0, 0));
        pending_samples.push_back(mk(2, 2, 2048, 1, 1, 1, 0, 0));
        pending_samples.push_back(mk(3, 3, 4095, 1, 1, 1, 0, 0));
        pending_samples.push_back(mk(4, 0, 1030, 1, 0, 1, 0, 0));
        pending_samples.push_back(mk(5, 0, 1024, 1, 1, 1, 1, 0));
        pending_samples.push_back(mk(6, 0, 1024, 1, 1, 0, 0, 0));
        pending_samples.push_back(mk(7, 0, 1032, 1, 1, 1, 0, 0));
        pending_samples.push_back(mk(8, 0, 1015, 1, 1, 1, 0, 0));
        pending_samples.push_back(mk(15, 15, 1054, 1, 1, 1, 0, 1));
        pending_samples.push_back(mk(0, 0, 1054, 1, 1, 1, 0, 0));
        pending_samples.push_back(mk(1, 1, 1024, 1, 1, 1, 0, 0));
        pending_samples.push_back(mk(2, 2, 1040, 1, 1, 1, 0, 0));
        pending_samples.push_back(mk(3, 15, 1024, 1, 1, 1, 0, 0));
        pending_samples.push_back(mk(15, 0, 1054, 1, 1, 1, 0, 0));
        pending_samples.push_back(mk(9, 0, 1024, 0, 1, 1, 0, 1));
        pending_samples.push_back(mk(0, 0, 1054, 1, 1, 1, 0, 0));
        pending_samples.push_back(mk(4, 0, 1024, 1, 1, 1, 0, 0));
        pending_samples.push_back(mk(14, 7, 2048, 1, 1, 1, 0, 1));
        wait_idle();

        set_all(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd4);
        run_phase(1'b0);
        set_all(16'd7, 16'd1, 16'd15, 16'hFFFF, 16'd0);
        run_phase(1'b1);
        set_all(16'd1, 16'd1, 16'd3, 16'h0000, 16'd16);
        run_phase(1'b0);
        set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_phase(1'b0);
        set_all(16'd4, 16'd0, 16'd5, 16'hA5A5, 16'd31);
        run_phase(1'b0);
        set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_phase(1'b1);
        set_all(16'd2, 16'd1, 16'd0, 16'hFFFF, 16'd8);
        run_phase(1'b0);
        set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_phase(1'b0);

        if (mismatches == 0)
            $display("tb_stick_dead_zone_and_center_detect_top: done, clean");
        else
            $display("tb_stick_dead_zone_and_center_detect_top: done, errors");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("timeout: %0d words still expected", expected_values.size());
        $display("tb_stick_dead_zone_and_center_detect_top: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
src/sdzcd_pkg.sv
src/sdzcd_in_if.sv
src/sdzcd_out_if.sv
src/sdzcd_cfg_if.sv
src/sdzcd_front.sv
src/sdzcd_fifo.sv
src/sdzcd_back.sv
src/stick_dead_zone_and_center_detect_top.sv
test/tb_stick_dead_zone_and_center_detect_top.sv
